// ----- design/bfa_pkg.sv -----
// ---------------------------------------------------------------------------
// bfa_pkg - shared types and constants of the bitmap frame allocator
// Map geometry, status codes, job kinds and the job record that passes
// from the front end to the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

   localparam int NUM_FRAMES  = 1024;
   localparam int FRAME_SHIFT = 12;
   localparam int WORD_W      = 32;
   localparam int BIT_W       = 5;
   localparam int NUM_WORDS   = (NUM_FRAMES + WORD_W - 1) / WORD_W;
   localparam int WADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int FIDX_W      = WADDR_W + BIT_W;
   localparam int CNT_W       = $clog2(NUM_FRAMES + 1);
   localparam int PAGE_W      = 64 - FRAME_SHIFT;

   localparam logic [63:0]        BASE_AT_RESET = 64'h0000_0000_0080_0000;
   localparam logic [WADDR_W-1:0] LAST_WORD     = WADDR_W'(NUM_WORDS - 1);
   localparam logic [FIDX_W-1:0]  LAST_FRAME    = FIDX_W'(NUM_FRAMES - 1);
   localparam logic [PAGE_W-1:0]  PAGE_LIMIT    = PAGE_W'(NUM_FRAMES);

   // result status codes
   localparam logic [2:0] ST_ALLOCATED = 3'd0;
   localparam logic [2:0] ST_NONE_LEFT = 3'd1;
   localparam logic [2:0] ST_FREED     = 3'd2;
   localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
   localparam logic [2:0] ST_WAS_FREE  = 3'd4;

   // request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // job kinds after classification
   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_FREE  = 2'd1;
   localparam logic [1:0] KIND_BAD   = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [FIDX_W-1:0] frame;
   } job_type;

   // bits of the last map word that lie past the last frame read as used
   function automatic logic [WORD_W-1:0] tail_mask();
      logic [WORD_W-1:0] m;
      m = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if ((NUM_WORDS - 1) * WORD_W + i >= NUM_FRAMES) begin
            m[i] = 1'b1;
         end
      end
      return m;
   endfunction

   localparam logic [WORD_W-1:0] TAIL_MASK = tail_mask();

endpackage

`default_nettype wire

// ----- design/bfa_ram.sv -----
// ---------------------------------------------------------------------------
// bfa_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- design/bfa_front.sv -----
// ---------------------------------------------------------------------------
// bfa_front - request intake and classification
// Checks free addresses against the region, turns each request into a job
// and holds jobs in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module bfa_front import bfa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [63:0] region_base,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // address
   input  wire logic        req_tuser,   // opcode
   output logic             job_valid,
   input  wire logic        job_ready,
   output job_type          job
);

   logic [64:0]       diff;
   logic [63:0]       offset;
   logic [PAGE_W-1:0] page;
   logic              bad_addr;
   job_type           new_job;

   job_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        push, pop;

   // borrow out of the subtract flags an address below the region
   assign diff     = {1'b0, req_tdata} - {1'b0, region_base};
   assign offset   = diff[63:0];
   assign page     = offset[63:FRAME_SHIFT];
   assign bad_addr = diff[64] || (|offset[FRAME_SHIFT-1:0]) || (page >= PAGE_LIMIT);

   always_comb begin
      new_job.frame = page[FIDX_W-1:0];
      if (req_tuser == OP_ALLOC) begin
         new_job.kind = KIND_ALLOC;
      end else if (bad_addr) begin
         new_job.kind = KIND_BAD;
      end else begin
         new_job.kind = KIND_FREE;
      end
   end

   assign req_tready = (fill_ff != 2'd2);
   assign job_valid  = (fill_ff != 2'd0);
   assign job        = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = job_valid && job_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

`default_nettype wire

// ----- design/bfa_back.sv -----
// ---------------------------------------------------------------------------
// bfa_back - job execution over the used map
// Scans the map one word per cycle for allocations, clears bits for frees,
// keeps the used count and search hint, and drives the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bfa_back import bfa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [63:0] region_base,
   input  wire logic        job_valid,
   output logic             job_ready,
   input  wire job_type     job,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_frame_address,
   output logic [2:0]       rsp_status,
   output logic [10:0]      rsp_used_count
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FREE  = 2'd2;
   localparam logic [1:0] S_REPLY = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [WADDR_W-1:0]   word_ff, word_in;
   logic                 first_ff, first_in;
   logic [FIDX_W-1:0]    hint_ff, hint_in;
   logic [FIDX_W-1:0]    frame_ff, frame_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [NUM_WORDS-1:0] rowv_ff, rowv_in;
   logic                 rdv_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_addr_ff, rsp_addr_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [CNT_W+10:0]    count_ext;

   logic                 slot_free;
   logic [WADDR_W-1:0]   rd_addr;
   logic [WORD_W-1:0]    rd_raw, word_data, eff;
   logic [BIT_W-1:0]     pos;
   logic [FIDX_W-1:0]    found;
   logic                 wr_en;
   logic [WORD_W-1:0]    wr_data;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign job_ready = (state_ff == S_IDLE) && slot_free;

   always_comb begin
      case (state_ff)
         S_IDLE: begin
            if (job.kind == KIND_FREE) begin
               rd_addr = job.frame[FIDX_W-1:BIT_W];
            end else begin
               rd_addr = hint_ff[FIDX_W-1:BIT_W];
            end
         end
         S_SCAN:  rd_addr = word_ff + WADDR_W'(1);
         default: rd_addr = word_ff;
      endcase
   end

   bfa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // rows never written since reset read as all free
   assign word_data = rdv_ff ? rd_raw : '0;

   always_comb begin
      eff = word_data;
      if (first_ff) begin
         eff = eff | ((WORD_W'(1) << hint_ff[BIT_W-1:0]) - WORD_W'(1));
      end
      if (word_ff == LAST_WORD) begin
         eff = eff | TAIL_MASK;
      end
   end

   // lowest clear bit of the masked word
   always_comb begin
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!eff[i]) begin
            pos = BIT_W'(i);
         end
      end
   end

   assign found = {word_ff, pos};

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      first_in      = first_ff;
      hint_in       = hint_ff;
      frame_in      = frame_ff;
      count_in      = count_ff;
      rowv_in       = rowv_ff;
      wr_en         = 1'b0;
      wr_data       = word_data;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            if (job_valid && job_ready) begin
               case (job.kind)
                  KIND_ALLOC: begin
                     word_in  = hint_ff[FIDX_W-1:BIT_W];
                     first_in = 1'b1;
                     state_in = S_SCAN;
                  end
                  KIND_FREE: begin
                     word_in  = job.frame[FIDX_W-1:BIT_W];
                     frame_in = job.frame;
                     state_in = S_FREE;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_addr_in   = '0;
                     rsp_status_in = ST_BAD_ADDR;
                     rsp_count_in  = count_ff;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!(&eff)) begin
               wr_en            = 1'b1;
               wr_data          = word_data | (WORD_W'(1) << pos);
               rowv_in[word_ff] = 1'b1;
               count_in         = count_ff + CNT_W'(1);
               frame_in         = found;
               hint_in          = (found == LAST_FRAME) ? '0 : found + FIDX_W'(1);
               state_in         = S_REPLY;
            end else if (word_ff == LAST_WORD) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ST_NONE_LEFT;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end else begin
               // advance to the next word
               word_in  = word_ff + WADDR_W'(1);
               first_in = 1'b0;
            end
         end
         S_FREE: begin
            rsp_valid_in = 1'b1;
            rsp_addr_in  = '0;
            state_in     = S_IDLE;
            if (word_data[frame_ff[BIT_W-1:0]]) begin
               wr_en            = 1'b1;
               wr_data          = word_data & ~(WORD_W'(1) << frame_ff[BIT_W-1:0]);
               rowv_in[word_ff] = 1'b1;
               count_in         = (count_ff != '0) ? count_ff - CNT_W'(1) : count_ff;
               if (frame_ff < hint_ff) begin
                  hint_in = frame_ff;
               end
               rsp_status_in = ST_FREED;
               rsp_count_in  = (count_ff != '0) ? count_ff - CNT_W'(1) : count_ff;
            end else begin
               rsp_status_in = ST_WAS_FREE;
               rsp_count_in  = count_ff;
            end
         end
         S_REPLY: begin
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = region_base + (64'(frame_ff) << FRAME_SHIFT);
            rsp_status_in = ST_ALLOCATED;
            rsp_count_in  = count_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= 1'b0;
         hint_ff      <= '0;
         count_ff     <= '0;
         rowv_ff      <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         hint_ff      <= hint_in;
         count_ff     <= count_in;
         rowv_ff      <= rowv_in;
         rdv_ff       <= rowv_ff[rd_addr];
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      frame_ff      <= frame_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign count_ext         = {11'b0, rsp_count_ff};
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_frame_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_used_count    = count_ext[10:0];

endmodule

`default_nettype wire

// ----- design/bitmap_frame_allocator.sv -----
// ---------------------------------------------------------------------------
// bitmap_frame_allocator - 4 KB physical frame allocator, top level
// Requests enter on req_ (tuser: opcode 0 allocate, 1 free; tdata: address
// of the frame to free). Each request yields one transfer on rsp_ with the
// frame address, a status in tuser and the used frame count.
// csr_ writes region_base, the byte address of frame zero; write it only
// while no request is outstanding.
// A free reads its map word on acceptance and answers from S_FREE; a
// rejected free answers from S_IDLE. An allocation scans in S_SCAN from
// the search hint, passing over up to 31 32-bit map words, one word of the
// used-map RAM per cycle through its single read port, and answers via
// S_REPLY, or from S_SCAN with no frame left. New jobs are taken only in
// S_IDLE, one per cycle for rejected frees while rsp_tready is high.
// Requests are classified on entry and wait in a two-entry queue, so the
// intake keeps accepting while the back end works or the result waits.
// A stalled rsp_ holds its result and the back end takes no new job until
// it is transferred; the queue then fills and req_tready drops.
// Reset empties the queue, marks every frame free (per-row valid bits, no
// clearing pass), zeroes the count and hint and sets region_base to
// 0x800000.
// ---------------------------------------------------------------------------
`default_nettype none

module bitmap_frame_allocator import bfa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] address
   input  wire logic        req_tuser,   // [0] opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // [63:0] frame_address, [74:64] used_count, zero pad
   output logic [2:0]       rsp_tuser,   // [2:0] status
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [63:0] csr_data     // region_base
);

   logic [63:0] base_ff, base_in;
   logic        job_valid;
   logic        job_ready;
   job_type     job;
   logic [63:0] frame_address;
   logic [10:0] used_count;

   assign csr_ready = 1'b1;
   assign base_in   = (csr_valid && csr_ready) ? csr_data : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_AT_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   bfa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .region_base (base_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job         (job)
   );

   bfa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .region_base       (base_ff),
      .job_valid         (job_valid),
      .job_ready         (job_ready),
      .job               (job),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_frame_address (frame_address),
      .rsp_status        (rsp_tuser),
      .rsp_used_count    (used_count)
   );

   assign rsp_tdata = {5'b0, used_count, frame_address};

endmodule

`default_nettype wire
